// ===== rtl/core/region_priority_buffer_cache_macros.svh =====
// ----------------------------------------------------------------------------
// Region priority buffer cache: assertion macros
// Shared property shapes for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef REGION_PRIORITY_BUFFER_CACHE_MACROS_SVH
`define REGION_PRIORITY_BUFFER_CACHE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RPBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpbc_pkg
// Constants, types and the region classifier of the region priority cache.
// ----------------------------------------------------------------------------
package rpbc_pkg;

  localparam int Ways       = 4;
  localparam int Sets       = 512;
  localparam int SetStride  = 4096;
  localparam int HistDepth  = 64;
  localparam int AddrW      = 32;
  localparam int TagLsb     = 21;
  localparam int TagW       = AddrW - TagLsb;
  localparam int SetLsb     = $clog2(SetStride);
  localparam int SetW       = $clog2(Sets);
  localparam int WayW       = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int HistIdxW   = $clog2(HistDepth);
  localparam int HistCntW   = $clog2(HistDepth + 1);
  localparam int Regions    = 4;
  localparam int RegW       = 2;

  typedef logic [RegW-1:0] region_t;

  // One way of a set row.
  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
    region_t         region;
  } entry_t;

  typedef entry_t [Ways-1:0] row_t;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_PEEK   = 2'd0,
    MODE_CHECK  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MINMAX,
    ST_BOUND,
    ST_COUNT,
    ST_SORT,
    ST_SWP_RD,
    ST_SWP_WR,
    ST_LK_RD,
    ST_LOOK
  } state_e;

  // Region of an address against the three boundaries.
  function automatic region_t classify(logic [AddrW-1:0] a, logic [AddrW-1:0] b0,
                                       logic [AddrW-1:0] b1, logic [AddrW-1:0] b2);
    region_t r;
    if (a < b0)      r = 2'd0;
    else if (a < b1) r = 2'd1;
    else if (a < b2) r = 2'd2;
    else             r = 2'd3;
    return r;
  endfunction

endpackage

// ===== rtl/core/region_priority_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// region_priority_buffer_cache
// Set-associative block buffer with region-priority victim selection.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries mode and addr; the output
// channel (out_valid_o / out_stall_i) returns hit, way and replaced, one
// transaction per input transaction, in order.
// An ordinary item is accepted in ST_IDLE, which issues the set-row read;
// ST_LOOK then evaluates the registered row and, once the output register
// is free, loads it, writes the row back for an insert and returns to
// ST_IDLE for the next item.
// A check that finds the history full first rebuilds the classifier: min/max
// over the history, the boundaries, the region counts, the priority sort and
// a read and a write per set to reclassify the rows, then the lookup.
// After reset the block clears all 512 set rows, one per cycle, with
// in_stall_o high; then it accepts items.
// The output is a register: a new item is accepted while a result waits,
// and a finished item holds in the evaluate step while the receiver stalls.
// ----------------------------------------------------------------------------
`include "region_priority_buffer_cache_macros.svh"

module region_priority_buffer_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_mode_i,
  input  logic [31:0] in_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_hit_o,
  output logic [1:0]  out_way_o,
  output logic        out_replaced_o
);

  localparam int AW = rpbc_pkg::AddrW;

  rpbc_pkg::state_e state_q, state_d;

  // item registers and their tag and set fields
  logic [1:0]                     mode_q;
  logic [AW-1:0]                  addr_q;
  logic [rpbc_pkg::TagW-1:0]      item_tag;
  logic [rpbc_pkg::SetW-1:0]      item_set;

  // classifier state
  logic [rpbc_pkg::HistCntW-1:0]  hcnt_q;
  logic [AW-1:0]                  bnd_q [3];
  rpbc_pkg::region_t              prio_q [rpbc_pkg::Regions];

  // rebuild working registers
  logic [rpbc_pkg::HistCntW-1:0]  idx_q;
  logic                           hv_q;
  logic [AW-1:0]                  lo_q, hi_q;
  logic [rpbc_pkg::HistCntW-1:0]  cnt_q [rpbc_pkg::Regions];
  logic [rpbc_pkg::Regions-1:0]   taken_q;
  logic [1:0]                     sj_q;
  logic [rpbc_pkg::SetW-1:0]      row_q;

  // history memory
  logic [AW-1:0]                  hist_mem [rpbc_pkg::HistDepth];
  logic [AW-1:0]                  hist_rd_q;
  logic                           hist_we, hist_re;

  // row RAM
  logic                           ram_we, ram_re;
  logic [rpbc_pkg::SetW-1:0]      ram_waddr, ram_raddr;
  rpbc_pkg::row_t                 ram_wdata, ram_rdata;

  // output register
  logic                           out_valid_q, out_hit_q, out_rep_q;
  logic [1:0]                     out_way_q;
  logic                           out_free, look_fire;

  logic                           accept;

  assign item_tag = addr_q[rpbc_pkg::TagLsb +: rpbc_pkg::TagW];
  assign item_set = addr_q[rpbc_pkg::SetLsb +: rpbc_pkg::SetW];

  assign in_stall_o = (state_q != rpbc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign look_fire  = (state_q == rpbc_pkg::ST_LOOK) && out_free;

  rpbc_tag_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // lookup / victim evaluation on the read row
  logic                     look_hit, look_full;
  logic [rpbc_pkg::WayW-1:0] victim;
  rpbc_pkg::region_t        ins_region;
  rpbc_pkg::row_t           ins_row;

  always_comb begin
    logic found;
    look_hit  = 1'b0;
    look_full = 1'b1;
    victim    = '0;
    found     = 1'b0;
    for (int w = 0; w < rpbc_pkg::Ways; w++) begin
      if (ram_rdata[w].valid && ram_rdata[w].tag == item_tag) look_hit = 1'b1;
      if (!ram_rdata[w].valid) look_full = 1'b0;
    end
    if (look_full) begin
      for (int j = 0; j < rpbc_pkg::Regions; j++) begin
        for (int w = 0; w < rpbc_pkg::Ways; w++) begin
          if (!found && ram_rdata[w].region == prio_q[j]) begin
            victim = rpbc_pkg::WayW'(w);
            found  = 1'b1;
          end
        end
      end
    end else begin
      for (int w = rpbc_pkg::Ways - 1; w >= 0; w--) begin
        if (!ram_rdata[w].valid) victim = rpbc_pkg::WayW'(w);
      end
    end
    ins_region = rpbc_pkg::classify(addr_q, bnd_q[0], bnd_q[1], bnd_q[2]);
    ins_row    = ram_rdata;
    ins_row[victim].valid  = 1'b1;
    ins_row[victim].tag    = item_tag;
    ins_row[victim].region = ins_region;
  end

  // reclassified row for the sweep
  rpbc_pkg::row_t swp_row;

  always_comb begin
    logic [AW-1:0] a;
    swp_row = ram_rdata;
    for (int w = 0; w < rpbc_pkg::Ways; w++) begin
      a = (AW'(ram_rdata[w].tag) << rpbc_pkg::TagLsb) |
          (AW'(row_q) << rpbc_pkg::SetLsb);
      swp_row[w].region = rpbc_pkg::classify(a, bnd_q[0], bnd_q[1], bnd_q[2]);
    end
  end

  // priority pick: fewest among untaken, ties to the lower region
  logic [1:0] pick;

  always_comb begin
    logic [rpbc_pkg::HistCntW-1:0] best;
    logic                          have;
    pick = '0;
    best = '0;
    have = 1'b0;
    for (int i = 0; i < rpbc_pkg::Regions; i++) begin
      if (!taken_q[i] && (!have || cnt_q[i] < best)) begin
        best = cnt_q[i];
        pick = 2'(i);
        have = 1'b1;
      end
    end
  end

  // next state and memory control
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = row_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = item_set;
    hist_we   = 1'b0;
    hist_re   = 1'b0;
    case (state_q)
      rpbc_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (row_q == rpbc_pkg::SetW'(rpbc_pkg::Sets - 1)) state_d = rpbc_pkg::ST_IDLE;
      end
      rpbc_pkg::ST_IDLE: begin
        if (accept) begin
          ram_re    = 1'b1;
          ram_raddr = in_addr_i[rpbc_pkg::SetLsb +: rpbc_pkg::SetW];
          state_d   = rpbc_pkg::ST_LOOK;
          if (in_mode_i == rpbc_pkg::MODE_CHECK) begin
            if (hcnt_q < rpbc_pkg::HistCntW'(rpbc_pkg::HistDepth)) begin
              hist_we = 1'b1;
            end else begin
              ram_re  = 1'b0;
              state_d = rpbc_pkg::ST_MINMAX;
            end
          end
        end
      end
      rpbc_pkg::ST_MINMAX, rpbc_pkg::ST_COUNT: begin
        if (idx_q == rpbc_pkg::HistCntW'(rpbc_pkg::HistDepth)) begin
          state_d = (state_q == rpbc_pkg::ST_MINMAX) ? rpbc_pkg::ST_BOUND
                                                      : rpbc_pkg::ST_SORT;
        end else begin
          hist_re = 1'b1;
        end
      end
      rpbc_pkg::ST_BOUND: state_d = rpbc_pkg::ST_COUNT;
      rpbc_pkg::ST_SORT: begin
        if (sj_q == 2'(rpbc_pkg::Regions - 1)) state_d = rpbc_pkg::ST_SWP_RD;
      end
      rpbc_pkg::ST_SWP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = row_q;
        state_d   = rpbc_pkg::ST_SWP_WR;
      end
      rpbc_pkg::ST_SWP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = swp_row;
        state_d   = (row_q == rpbc_pkg::SetW'(rpbc_pkg::Sets - 1)) ? rpbc_pkg::ST_LK_RD
                                                                    : rpbc_pkg::ST_SWP_RD;
      end
      rpbc_pkg::ST_LK_RD: begin
        ram_re  = 1'b1;
        state_d = rpbc_pkg::ST_LOOK;
      end
      rpbc_pkg::ST_LOOK: begin
        if (out_free) begin
          state_d = rpbc_pkg::ST_IDLE;
          if (mode_q == rpbc_pkg::MODE_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = item_set;
            ram_wdata = ins_row;
          end
        end
      end
      default: state_d = rpbc_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpbc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hcnt_q[rpbc_pkg::HistIdxW-1:0]] <= in_addr_i;
    if (hist_re) hist_rd_q <= hist_mem[idx_q[rpbc_pkg::HistIdxW-1:0]];
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_mode_i;
      addr_q <= in_addr_i;
    end
  end

  // rebuild datapath
  logic [AW-1:0] interval;
  assign interval = (hi_q - lo_q) >> 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q  <= '0;
      bnd_q   <= '{AW'(0), AW'(1), AW'(2)};
      for (int i = 0; i < rpbc_pkg::Regions; i++) prio_q[i] <= rpbc_pkg::region_t'(i);
      idx_q   <= '0;
      hv_q    <= 1'b0;
      lo_q    <= '1;
      hi_q    <= '0;
      for (int i = 0; i < rpbc_pkg::Regions; i++) cnt_q[i] <= '0;
      taken_q <= '0;
      sj_q    <= '0;
      row_q   <= '0;
    end else begin
      hv_q <= hist_re;
      case (state_q)
        rpbc_pkg::ST_CLEAR: row_q <= row_q + 1'b1;
        rpbc_pkg::ST_IDLE: begin
          if (hist_we) hcnt_q <= hcnt_q + 1'b1;
          idx_q <= '0;
          lo_q  <= '1;
          hi_q  <= '0;
        end
        rpbc_pkg::ST_MINMAX: begin
          if (hist_re) idx_q <= idx_q + 1'b1;
          if (hv_q) begin
            if (hist_rd_q > hi_q) hi_q <= hist_rd_q;
            if (hist_rd_q < lo_q) lo_q <= hist_rd_q;
          end
        end
        rpbc_pkg::ST_BOUND: begin
          bnd_q[0] <= lo_q + interval;
          bnd_q[1] <= lo_q + (interval << 1);
          bnd_q[2] <= lo_q + interval + (interval << 1);
          idx_q    <= '0;
          for (int i = 0; i < rpbc_pkg::Regions; i++) cnt_q[i] <= '0;
          taken_q  <= '0;
          sj_q     <= '0;
        end
        rpbc_pkg::ST_COUNT: begin
          if (hist_re) idx_q <= idx_q + 1'b1;
          if (hv_q) begin
            cnt_q[rpbc_pkg::classify(hist_rd_q, bnd_q[0], bnd_q[1], bnd_q[2])] <=
              cnt_q[rpbc_pkg::classify(hist_rd_q, bnd_q[0], bnd_q[1], bnd_q[2])] + 1'b1;
          end
          row_q <= '0;
        end
        rpbc_pkg::ST_SORT: begin
          prio_q[sj_q]  <= pick;
          taken_q[pick] <= 1'b1;
          sj_q          <= sj_q + 1'b1;
        end
        rpbc_pkg::ST_SWP_WR: begin
          row_q <= row_q + 1'b1;
          if (row_q == rpbc_pkg::SetW'(rpbc_pkg::Sets - 1)) hcnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (look_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_fire) begin
      out_hit_q <= (mode_q == rpbc_pkg::MODE_PEEK || mode_q == rpbc_pkg::MODE_CHECK)
                   && look_hit;
      out_way_q <= (mode_q == rpbc_pkg::MODE_INSERT) ? 2'(victim) : 2'd0;
      out_rep_q <= (mode_q == rpbc_pkg::MODE_INSERT) && look_full;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_hit_o      = out_hit_q;
  assign out_way_o      = out_way_q;
  assign out_replaced_o = out_rep_q;

  // checks
  `RPBC_ASSERT_NOW(a_hcnt_bound, clk_i, rst_ni, 1'b1, hcnt_q <= rpbc_pkg::HistCntW'(rpbc_pkg::HistDepth))
  `RPBC_ASSERT_NOW(a_rep_no_hit, clk_i, rst_ni, out_valid_o && out_replaced_o, !out_hit_o)
  `RPBC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

// ===== rtl/core/rpbc_tag_ram.sv =====
// ----------------------------------------------------------------------------
// rpbc_tag_ram
// Set row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpbc_tag_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [rpbc_pkg::SetW-1:0]  waddr_i,
  input  rpbc_pkg::row_t             wdata_i,
  input  logic                       re_i,
  input  logic [rpbc_pkg::SetW-1:0]  raddr_i,
  output rpbc_pkg::row_t             rdata_o
);

  rpbc_pkg::row_t mem [rpbc_pkg::Sets];
  rpbc_pkg::row_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
